// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FGS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/fgs_pkg.sv =====
package fgs_pkg;
	localparam int GRID_SIZE_DEF = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [30:0] VISC_RST  = 31'd66;
	localparam logic [30:0] INVD_RST  = 31'd6554;
	localparam logic [31:0] BODY_RST  = 32'd0;
	localparam logic [30:0] TSTEP_RST = 31'd2621;
	localparam logic [30:0] PGAIN_RST = 31'd655360000;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_STEP = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VISC  = 3'd0,
		REG_INVD  = 3'd1,
		REG_BODY  = 3'd2,
		REG_TSTEP = 3'd3,
		REG_PGAIN = 3'd4
	} reg_idx_t;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > SAT_MAX) return 32'sh7FFFFFFF;
		if (x < SAT_MIN) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd32768) >>> 16;
		return sat32(66'(t));
	endfunction
endpackage

// ===== sv/fgs_ram.sv =====
module fgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/fluid_grid_step_core.sv =====
// channel  dir  signals                          content
// s        in   s_tvalid s_tready s_tdata s_tuser  command, cell coordinates, load values
// m        out  m_tvalid m_tready m_tdata m_tuser  read result or step maxima
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data  register writes, always ready
// A load writes the cell at the beat; a read registers the RAM word, then loads the output register.
// A step runs a velocity pass over all cells, each with 9 fetch beats on the single
// read port and 11 products on the shared multiplier, then a pressure pass with
// 5 fetches and one product per cell. Intake is closed for the whole step.
// Reset is asynchronous and clears control and registers; grid memory is not cleared.
// The output register holds a result until taken; intake waits while it is full.
`include "assert_macros.svh"
module fluid_grid_step_core #(
	parameter int GRID_SIZE = fgs_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// col[5:0], row[11:6], u_in[43:12], v_in[75:44], p_in[107:76], weight_in[124:108]
	input  logic [127:0]                   s_tdata,
	// command[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// u_out[31:0], v_out[63:32], p_out[95:64]
	output logic [95:0]                    m_tdata,
	// kind[0]
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	localparam int IDX_W = $clog2(GRID_SIZE);
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int MW    = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

	localparam logic [AW-1:0] G1 = AW'(GRID_SIZE);
	localparam logic [AW-1:0] G3 = AW'(3 * GRID_SIZE);
	localparam logic [AW-1:0] GG = AW'(CELLS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_GAIN_MUL, ST_GAIN, ST_V_FETCH, ST_V_CALC, ST_P_FETCH, ST_P_CALC, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OFF_C, OFF_CP1, OFF_CM1, OFF_CP3, OFF_CM3, OFF_RP1, OFF_RM1, OFF_RP3, OFF_RM3
	} off_t;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a, b);
		return fgs_pkg::sat32(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a, b);
		return fgs_pkg::sat32(66'(a) - 66'(b));
	endfunction

	function automatic logic signed [31:0] half_diff(input logic signed [31:0] a, b);
		logic signed [33:0] d;
		d = 34'(a) - 34'(b) + 34'sd1;
		return fgs_pkg::sat32(66'(d >>> 1));
	endfunction

	function automatic logic signed [31:0] lap4(input logic signed [31:0] pc3, mc3, pc1, mc1,
			pr3, mr3, pr1, mr1);
		logic signed [35:0] s;
		s = 36'(pc3) + 36'(mc3) - 36'(pc1) - 36'(mc1)
			+ 36'(pr3) + 36'(mr3) - 36'(pr1) - 36'(mr1) + 36'sd2;
		return fgs_pkg::sat32(66'(s >>> 2));
	endfunction

	state_t state_q;
	logic rd_pend_q, bank_q;
	logic [IDX_W-1:0] c_q, r_q;
	logic [AW-1:0] k_q;
	logic [3:0] fi_q, step_q;
	logic [30:0] visc_q, invd_q, ts_q, pg_q;
	logic signed [31:0] ba_q;
	logic ov_q, okind_q;
	logic signed [31:0] ou_q, ovv_q, op_q, mu_q, mv_q, mp_q;

	logic cap_en_q;
	off_t cap_off_q;
	logic signed [31:0] uo_q [9];
	logic signed [31:0] vo_q [9];
	logic signed [31:0] po_q [9];
	logic [16:0] w_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] gain_q, wdt_q, t_q, convu_q, convv_q, fu_q, fv_q, ru_q, rv_q;
	logic signed [31:0] unew_q;

	logic s_fire, ld, last_cell, vwr, pwr, out_free, out_ld;
	fgs_pkg::cmd_t cmd;
	logic [5:0] col_in, row_in;
	logic [MW-1:0] cm, rm;
	logic [AW-1:0] in_addr, na, raddr, waddr;
	off_t off_sel;
	logic signed [31:0] u_rd, v_rd, p_rd, u0_rd, u1_rd, v0_rd, v1_rd;
	logic [16:0] w_rd;
	logic signed [31:0] u_wd, v_wd, p_wd, vnew, pnew, qres;
	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] uc, vc, gux, guy, gvx, gvy, gpx, gpy, lapu, lapv, divv;
	logic signed [34:0] dsum;

	assign cmd      = fgs_pkg::cmd_t'(s_tuser);
	assign out_free = !ov_q || m_tready;
	assign out_ld   = rd_pend_q || ((state_q == ST_DONE) && out_free);
	assign s_tready = (state_q == ST_IDLE) && !rd_pend_q && out_free;
	assign s_fire   = s_tvalid && s_tready;
	assign ld       = s_fire && (cmd == fgs_pkg::CMD_LOAD);
	assign cfg_ready = 1'b1;
	assign col_in   = s_tdata[5:0];
	assign row_in   = s_tdata[11:6];
	assign last_cell = (k_q == AW'(CELLS - 1));
	assign vwr      = (state_q == ST_V_CALC) && (step_q == 4'd11);
	assign pwr      = (state_q == ST_P_CALC) && (step_q == 4'd1);

	always_comb begin
		cm = MW'(col_in);
		rm = MW'(row_in);
		for (int i = 0; i < 8; i++) begin
			if (cm >= MW'(GRID_SIZE)) cm = cm - MW'(GRID_SIZE);
			if (rm >= MW'(GRID_SIZE)) rm = rm - MW'(GRID_SIZE);
		end
		in_addr = AW'(AW'(cm[IDX_W-1:0]) * G1) + AW'(rm[IDX_W-1:0]);
	end

	always_comb begin
		if (state_q == ST_P_FETCH) begin
			case (fi_q)
				4'd0: off_sel = OFF_CP1;
				4'd1: off_sel = OFF_CM1;
				4'd2: off_sel = OFF_RP1;
				4'd3: off_sel = OFF_RM1;
				default: off_sel = OFF_C;
			endcase
		end else begin
			off_sel = off_t'(fi_q);
		end
	end

	always_comb begin
		case (off_sel)
			OFF_CP1: na = (c_q == IDX_W'(GRID_SIZE - 1)) ? k_q + G1 - GG : k_q + G1;
			OFF_CM1: na = (c_q == '0) ? k_q - G1 + GG : k_q - G1;
			OFF_CP3: na = (c_q >= IDX_W'(GRID_SIZE - 3)) ? k_q + G3 - GG : k_q + G3;
			OFF_CM3: na = (c_q < IDX_W'(3)) ? k_q - G3 + GG : k_q - G3;
			OFF_RP1: na = (r_q == IDX_W'(GRID_SIZE - 1)) ? k_q + AW'(1) - G1 : k_q + AW'(1);
			OFF_RM1: na = (r_q == '0) ? k_q - AW'(1) + G1 : k_q - AW'(1);
			OFF_RP3: na = (r_q >= IDX_W'(GRID_SIZE - 3)) ? k_q + AW'(3) - G1 : k_q + AW'(3);
			OFF_RM3: na = (r_q < IDX_W'(3)) ? k_q - AW'(3) + G1 : k_q - AW'(3);
			default: na = k_q;
		endcase
	end

	assign raddr = (state_q == ST_IDLE) ? in_addr : na;
	assign waddr = (state_q == ST_IDLE) ? in_addr : k_q;

	assign uc   = uo_q[OFF_C];
	assign vc   = vo_q[OFF_C];
	assign gux  = half_diff(uo_q[OFF_CP1], uo_q[OFF_CM1]);
	assign guy  = half_diff(uo_q[OFF_RP1], uo_q[OFF_RM1]);
	assign gvx  = half_diff(vo_q[OFF_CP1], vo_q[OFF_CM1]);
	assign gvy  = half_diff(vo_q[OFF_RP1], vo_q[OFF_RM1]);
	assign gpx  = half_diff(po_q[OFF_CP1], po_q[OFF_CM1]);
	assign gpy  = half_diff(po_q[OFF_RP1], po_q[OFF_RM1]);
	assign lapu = lap4(uo_q[OFF_CP3], uo_q[OFF_CM3], uo_q[OFF_CP1], uo_q[OFF_CM1],
		uo_q[OFF_RP3], uo_q[OFF_RM3], uo_q[OFF_RP1], uo_q[OFF_RM1]);
	assign lapv = lap4(vo_q[OFF_CP3], vo_q[OFF_CM3], vo_q[OFF_CP1], vo_q[OFF_CM1],
		vo_q[OFF_RP3], vo_q[OFF_RM3], vo_q[OFF_RP1], vo_q[OFF_RM1]);
	assign dsum = 35'(uo_q[OFF_CP1]) - 35'(uo_q[OFF_CM1])
		+ 35'(vo_q[OFF_RP1]) - 35'(vo_q[OFF_RM1]) + 35'sd1;
	assign divv = fgs_pkg::sat32(66'(dsum >>> 1));

	assign qres = fgs_pkg::qround(prod_q);
	assign vnew = add_sat(vc, qres);
	assign pnew = sub_sat(po_q[OFF_C], qres);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_GAIN_MUL: begin
				mul_a = $signed({1'b0, pg_q});
				mul_b = $signed({1'b0, ts_q});
			end
			ST_P_CALC: begin
				mul_a = gain_q;
				mul_b = divv;
			end
			ST_V_CALC: begin
				case (step_q)
					4'd0: begin
						mul_a = $signed({15'd0, w_q});
						mul_b = $signed({1'b0, ts_q});
					end
					4'd1: begin mul_a = uc; mul_b = gux; end
					4'd2: begin mul_a = vc; mul_b = guy; end
					4'd3: begin mul_a = uc; mul_b = gvx; end
					4'd4: begin mul_a = vc; mul_b = gvy; end
					4'd5: begin mul_a = $signed({1'b0, visc_q}); mul_b = lapu; end
					4'd6: begin mul_a = $signed({1'b0, visc_q}); mul_b = lapv; end
					4'd7: begin mul_a = fu_q; mul_b = $signed({1'b0, invd_q}); end
					4'd8: begin mul_a = fv_q; mul_b = $signed({1'b0, invd_q}); end
					4'd9: begin mul_a = wdt_q; mul_b = ru_q; end
					4'd10: begin mul_a = wdt_q; mul_b = rv_q; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign u_wd = ld ? $signed(s_tdata[43:12]) : unew_q;
	assign v_wd = ld ? $signed(s_tdata[75:44]) : vnew;
	assign p_wd = ld ? $signed(s_tdata[107:76]) : pnew;

	fgs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram0 (
		.clk(clk), .we((ld && !bank_q) || (vwr && bank_q)), .waddr(waddr),
		.wdata(u_wd), .raddr(raddr), .rdata(u0_rd)
	);
	fgs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram1 (
		.clk(clk), .we((ld && bank_q) || (vwr && !bank_q)), .waddr(waddr),
		.wdata(u_wd), .raddr(raddr), .rdata(u1_rd)
	);
	fgs_ram #(.WIDTH(32), .DEPTH(CELLS)) v_ram0 (
		.clk(clk), .we((ld && !bank_q) || (vwr && bank_q)), .waddr(waddr),
		.wdata(v_wd), .raddr(raddr), .rdata(v0_rd)
	);
	fgs_ram #(.WIDTH(32), .DEPTH(CELLS)) v_ram1 (
		.clk(clk), .we((ld && bank_q) || (vwr && !bank_q)), .waddr(waddr),
		.wdata(v_wd), .raddr(raddr), .rdata(v1_rd)
	);
	fgs_ram #(.WIDTH(32), .DEPTH(CELLS)) p_ram (
		.clk(clk), .we(ld || pwr), .waddr(waddr),
		.wdata(p_wd), .raddr(raddr), .rdata(p_rd)
	);
	fgs_ram #(.WIDTH(17), .DEPTH(CELLS)) w_ram (
		.clk(clk), .we(ld), .waddr(waddr),
		.wdata(s_tdata[124:108]), .raddr(raddr), .rdata(w_rd)
	);

	assign u_rd = bank_q ? u1_rd : u0_rd;
	assign v_rd = bank_q ? v1_rd : v0_rd;

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cap_en_q) begin
			uo_q[cap_off_q] <= u_rd;
			vo_q[cap_off_q] <= v_rd;
			po_q[cap_off_q] <= p_rd;
			if (cap_off_q == OFF_C) w_q <= w_rd;
		end
		if (state_q == ST_GAIN) gain_q <= qres;
		if (state_q == ST_V_CALC) begin
			case (step_q)
				4'd1: wdt_q <= qres;
				4'd2: t_q <= qres;
				4'd3: convu_q <= add_sat(t_q, qres);
				4'd4: t_q <= qres;
				4'd5: convv_q <= add_sat(t_q, qres);
				4'd6: fu_q <= sub_sat(qres, gpx);
				4'd7: fv_q <= sub_sat(qres, gpy);
				4'd8: ru_q <= sub_sat(add_sat(qres, ba_q), convu_q);
				4'd9: rv_q <= sub_sat(add_sat(qres, ba_q), convv_q);
				4'd10: unew_q <= add_sat(uc, qres);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_q <= fgs_pkg::VISC_RST;
			invd_q <= fgs_pkg::INVD_RST;
			ba_q <= fgs_pkg::BODY_RST;
			ts_q <= fgs_pkg::TSTEP_RST;
			pg_q <= fgs_pkg::PGAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (fgs_pkg::reg_idx_t'(cfg_index))
				fgs_pkg::REG_VISC:  visc_q <= cfg_data[30:0];
				fgs_pkg::REG_INVD:  invd_q <= cfg_data[30:0];
				fgs_pkg::REG_BODY:  ba_q <= cfg_data;
				fgs_pkg::REG_TSTEP: ts_q <= cfg_data[30:0];
				fgs_pkg::REG_PGAIN: pg_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_pend_q <= 1'b0;
			bank_q <= 1'b0;
			c_q <= '0;
			r_q <= '0;
			k_q <= '0;
			fi_q <= '0;
			step_q <= '0;
			cap_en_q <= 1'b0;
			cap_off_q <= OFF_C;
			ov_q <= 1'b0;
			okind_q <= 1'b0;
			ou_q <= '0;
			ovv_q <= '0;
			op_q <= '0;
			mu_q <= '0;
			mv_q <= '0;
			mp_q <= '0;
		end else begin
			cap_en_q <= (state_q == ST_V_FETCH) || (state_q == ST_P_FETCH);
			cap_off_q <= off_sel;
			if (out_ld) ov_q <= 1'b1;
			else if (ov_q && m_tready) ov_q <= 1'b0;
			if (rd_pend_q) begin
				rd_pend_q <= 1'b0;
				okind_q <= 1'b0;
				ou_q <= u_rd;
				ovv_q <= v_rd;
				op_q <= p_rd;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						case (cmd)
							fgs_pkg::CMD_STEP: state_q <= ST_GAIN_MUL;
							fgs_pkg::CMD_READ: rd_pend_q <= 1'b1;
							default: ;
						endcase
					end
				end
				ST_GAIN_MUL: begin
					mu_q <= '0;
					mv_q <= '0;
					mp_q <= '0;
					c_q <= '0;
					r_q <= '0;
					k_q <= '0;
					fi_q <= '0;
					state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_V_FETCH;
				ST_V_FETCH: begin
					if (fi_q == 4'd8) begin
						fi_q <= '0;
						step_q <= '0;
						state_q <= ST_V_CALC;
					end else begin
						fi_q <= fi_q + 4'd1;
					end
				end
				ST_V_CALC: begin
					if (step_q == 4'd11) begin
						if (unew_q > mu_q) mu_q <= unew_q;
						if (vnew > mv_q) mv_q <= vnew;
						if (last_cell) begin
							bank_q <= ~bank_q;
							state_q <= ST_P_FETCH;
						end else begin
							state_q <= ST_V_FETCH;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_P_FETCH: begin
					if (fi_q == 4'd4) begin
						fi_q <= '0;
						step_q <= '0;
						state_q <= ST_P_CALC;
					end else begin
						fi_q <= fi_q + 4'd1;
					end
				end
				ST_P_CALC: begin
					if (step_q == 4'd1) begin
						if (pnew > mp_q) mp_q <= pnew;
						state_q <= last_cell ? ST_DONE : ST_P_FETCH;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						okind_q <= 1'b1;
						ou_q <= mu_q;
						ovv_q <= mv_q;
						op_q <= mp_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vwr || pwr) begin
				if (last_cell) begin
					k_q <= '0;
					c_q <= '0;
					r_q <= '0;
				end else begin
					k_q <= k_q + AW'(1);
					if (r_q == IDX_W'(GRID_SIZE - 1)) begin
						r_q <= '0;
						c_q <= c_q + IDX_W'(1);
					end else begin
						r_q <= r_q + IDX_W'(1);
					end
				end
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = okind_q;
	assign m_tdata  = {op_q, ovv_q, ou_q};

	`FGS_ASSERT_NEXT(a_read_result, clk, arst_n, rd_pend_q, m_tvalid && !m_tuser)
	`FGS_ASSERT_NEXT(a_step_closes, clk, arst_n, s_fire && (cmd == fgs_pkg::CMD_STEP), !s_tready)
	`FGS_ASSERT_NOW(a_wr_exclusive, clk, arst_n, vwr || pwr, !ld && !rd_pend_q)
endmodule
